>>> sv/rgbhsv_pkg.sv
// Shared constants and types for the RGB to HSV converter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rgbhsv_pkg;

  // Field widths
  localparam int unsigned CH_W  = 8;
  localparam int unsigned PIX_W = 3 * CH_W;
  localparam int unsigned HUE_W = 15;
  localparam int unsigned SAT_W = 9;

  // Divider geometry: quotient bits and partial remainder width
  localparam int unsigned Q_W   = 12;
  localparam int unsigned REM_W = CH_W + Q_W;

  // Hue scaling, degrees times 64
  localparam int unsigned HUE_SIXTY  = 3840;
  localparam int unsigned OFS_GREEN  = 7680;
  localparam int unsigned OFS_BLUE   = 15360;
  localparam int unsigned FULL_TURN  = 23040;

  // Signed width of the hue sum before wrapping
  localparam int unsigned HSUM_W = HUE_W + 2;

  // Two prep stages, one stage per quotient bit, one output stage
  localparam int unsigned PIPE_LATENCY = 3 + Q_W;

  // Sector holding the largest channel
  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // Per-pixel sideband that travels with the divider
  typedef struct packed {
    logic [CH_W-1:0] vmax;
    sector_t         sector;
    logic            neg;
    logic            grey;
  } side_t;

endpackage

>>> sv/rgbhsv_prep.sv
// Front stages: max/min search, sector pick, dividend forming.
// Depends on rgbhsv_pkg.
`timescale 1ns / 1ps

module rgbhsv_prep (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [rgbhsv_pkg::PIX_W-1:0] pixel_rgb,
  output logic                        dvd_valid,
  output rgbhsv_pkg::side_t           dvd_side,
  output logic [rgbhsv_pkg::REM_W-1:0] hue_dvd,
  output logic [rgbhsv_pkg::CH_W-1:0]  hue_dvs,
  output logic [rgbhsv_pkg::REM_W-1:0] sat_dvd
);
  import rgbhsv_pkg::*;

  logic [CH_W-1:0] r, g, b;
  logic [CH_W-1:0] vmax, vmin;
  logic signed [CH_W:0] diff;
  side_t           side_nxt;
  logic [CH_W-1:0] mag_nxt, span_nxt;

  logic            s1_valid_r;
  side_t           s1_side_r;
  logic [CH_W-1:0] s1_mag_r, s1_span_r;

  logic            s2_valid_r;
  side_t           s2_side_r;
  logic [REM_W-1:0] s2_hue_dvd_r, s2_sat_dvd_r;
  logic [CH_W-1:0] s2_span_r;
  logic [REM_W-1:0] hue_dvd_nxt, sat_dvd_nxt;

  // Stage 1: extremes, sector (red wins ties, then green), signed difference
  always_comb begin
    r = pixel_rgb[PIX_W-1 -: CH_W];
    g = pixel_rgb[2*CH_W-1 -: CH_W];
    b = pixel_rgb[CH_W-1:0];
    vmax = r;
    if (g > vmax) vmax = g;
    if (b > vmax) vmax = b;
    vmin = r;
    if (g < vmin) vmin = g;
    if (b < vmin) vmin = b;
    span_nxt = vmax - vmin;
    side_nxt.vmax = vmax;
    side_nxt.grey = (span_nxt == '0);
    if (vmax == r) begin
      side_nxt.sector = SEC_RED;
      diff = $signed({1'b0, g}) - $signed({1'b0, b});
    end else if (vmax == g) begin
      side_nxt.sector = SEC_GREEN;
      diff = $signed({1'b0, b}) - $signed({1'b0, r});
    end else begin
      side_nxt.sector = SEC_BLUE;
      diff = $signed({1'b0, r}) - $signed({1'b0, g});
    end
    side_nxt.neg = diff[CH_W];
    mag_nxt = diff[CH_W] ? CH_W'(-diff) : diff[CH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_side_r <= side_nxt;
    s1_mag_r  <= mag_nxt;
    s1_span_r <= span_nxt;
  end

  // Stage 2: mag * 3840 as (mag << 12) - (mag << 8); span * 256
  always_comb begin
    hue_dvd_nxt = (REM_W'(s1_mag_r) << 12) - (REM_W'(s1_mag_r) << 8);
    sat_dvd_nxt = REM_W'(s1_span_r) << 8;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_side_r    <= s1_side_r;
    s2_hue_dvd_r <= hue_dvd_nxt;
    s2_sat_dvd_r <= sat_dvd_nxt;
    s2_span_r    <= s1_span_r;
  end

  assign dvd_valid = s2_valid_r;
  assign dvd_side  = s2_side_r;
  assign hue_dvd   = s2_hue_dvd_r;
  assign hue_dvs   = s2_span_r;
  assign sat_dvd   = s2_sat_dvd_r;

endmodule

>>> sv/rgbhsv_div.sv
// Pipelined restoring divider, two lanes (hue term and saturation),
// one quotient bit per stage. Depends on rgbhsv_pkg.
`timescale 1ns / 1ps

module rgbhsv_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         dvd_valid,
  input  rgbhsv_pkg::side_t            dvd_side,
  input  logic [rgbhsv_pkg::REM_W-1:0] hue_dvd,
  input  logic [rgbhsv_pkg::CH_W-1:0]  hue_dvs,
  input  logic [rgbhsv_pkg::REM_W-1:0] sat_dvd,
  output logic                         q_valid,
  output rgbhsv_pkg::side_t            q_side,
  output logic [rgbhsv_pkg::Q_W-1:0]   hue_q,
  output logic                         hue_rem_nz,
  output logic [rgbhsv_pkg::Q_W-1:0]   sat_q
);
  import rgbhsv_pkg::*;

  logic             v_r    [Q_W];
  side_t            side_r [Q_W];
  logic [REM_W-1:0] hrem_r [Q_W];
  logic [REM_W-1:0] srem_r [Q_W];
  logic [CH_W-1:0]  hdvs_r [Q_W];
  logic [Q_W-1:0]   hq_r   [Q_W];
  logic [Q_W-1:0]   sq_r   [Q_W];

  // Saturation divisor is the value channel, carried in the sideband
  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int unsigned SH = Q_W - 1 - k;

    logic             v_in;
    side_t            sd_in;
    logic [REM_W-1:0] hr_in, sr_in;
    logic [CH_W-1:0]  hd_in;
    logic [Q_W-1:0]   hq_in, sq_in;
    logic [REM_W-1:0] hsh, ssh;
    logic             hbit, sbit;
    logic [REM_W-1:0] hrem_nxt, srem_nxt;

    if (k == 0) begin : g_first
      assign v_in  = dvd_valid;
      assign sd_in = dvd_side;
      assign hr_in = hue_dvd;
      assign sr_in = sat_dvd;
      assign hd_in = hue_dvs;
      assign hq_in = '0;
      assign sq_in = '0;
    end else begin : g_next
      assign v_in  = v_r[k-1];
      assign sd_in = side_r[k-1];
      assign hr_in = hrem_r[k-1];
      assign sr_in = srem_r[k-1];
      assign hd_in = hdvs_r[k-1];
      assign hq_in = hq_r[k-1];
      assign sq_in = sq_r[k-1];
    end

    // Compare-subtract against the divisor aligned to this quotient bit
    always_comb begin
      hsh      = REM_W'(hd_in) << SH;
      ssh      = REM_W'(sd_in.vmax) << SH;
      hbit     = (hr_in >= hsh);
      sbit     = (sr_in >= ssh);
      hrem_nxt = hbit ? (hr_in - hsh) : hr_in;
      srem_nxt = sbit ? (sr_in - ssh) : sr_in;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      side_r[k] <= sd_in;
      hrem_r[k] <= hrem_nxt;
      srem_r[k] <= srem_nxt;
      hdvs_r[k] <= hd_in;
      hq_r[k]   <= {hq_in[Q_W-2:0], hbit};
      sq_r[k]   <= {sq_in[Q_W-2:0], sbit};
    end
  end

  assign q_valid    = v_r[Q_W-1];
  assign q_side     = side_r[Q_W-1];
  assign hue_q      = hq_r[Q_W-1];
  assign hue_rem_nz = |hrem_r[Q_W-1];
  assign sat_q      = sq_r[Q_W-1];

endmodule

>>> sv/rgbhsv_post.sv
// Output stage: floor correction, sector offset, wrap, grey override.
// Depends on rgbhsv_pkg.
`timescale 1ns / 1ps

module rgbhsv_post (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  rgbhsv_pkg::side_t            q_side,
  input  logic [rgbhsv_pkg::Q_W-1:0]   hue_q,
  input  logic                         hue_rem_nz,
  input  logic [rgbhsv_pkg::Q_W-1:0]   sat_q,
  output logic                         out_valid,
  output logic [rgbhsv_pkg::HUE_W-1:0] out_hue,
  output logic [rgbhsv_pkg::SAT_W-1:0] out_saturation,
  output logic [rgbhsv_pkg::CH_W-1:0]  out_brightness
);
  import rgbhsv_pkg::*;

  logic [Q_W:0]              mag;
  logic signed [HSUM_W-1:0]  ofs_s, term_s, sum_s, wrap_s;
  logic [HUE_W-1:0]          hue_nxt;
  logic [SAT_W-1:0]          sat_nxt;

  logic                      valid_r;
  logic [HUE_W-1:0]          hue_r;
  logic [SAT_W-1:0]          sat_r;
  logic [CH_W-1:0]           bri_r;

  // Negative difference rounds toward minus infinity: -(q + (rem != 0))
  always_comb begin
    mag = (Q_W+1)'(hue_q) + (Q_W+1)'(hue_rem_nz & q_side.neg);
    term_s = q_side.neg ? -$signed(HSUM_W'(mag)) : $signed(HSUM_W'(mag));
    case (q_side.sector)
      SEC_RED:   ofs_s = '0;
      SEC_GREEN: ofs_s = $signed(HSUM_W'(OFS_GREEN));
      SEC_BLUE:  ofs_s = $signed(HSUM_W'(OFS_BLUE));
      default:   ofs_s = '0;
    endcase
    sum_s  = ofs_s + term_s;
    wrap_s = sum_s[HSUM_W-1] ? (sum_s + $signed(HSUM_W'(FULL_TURN))) : sum_s;
    // Grey and black pixels: hue and saturation are zero
    hue_nxt = q_side.grey ? '0 : wrap_s[HUE_W-1:0];
    sat_nxt = q_side.grey ? '0 : sat_q[SAT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    hue_r <= hue_nxt;
    sat_r <= sat_nxt;
    bri_r <= q_side.vmax;
  end

  assign out_valid      = valid_r;
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_brightness = bri_r;

endmodule

>>> sv/rgb_to_hsv_converter_top.sv
// RGB to HSV converter, fully pipelined: one pixel may start every cycle.
// From the start transfer to the out_valid strobe a pixel passes through
// two front stages, twelve divider stages (one quotient bit each), one output stage.
// Throughput is one pixel per clock; busy is high only while rst_n is low.
// Synchronous active-low reset clears all valid bits; in-flight pixels are dropped.
// Results are strobed for one cycle; the receiver cannot stall. Depends on rgbhsv_pkg.
`timescale 1ns / 1ps

module rgb_to_hsv_converter_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [rgbhsv_pkg::PIX_W-1:0] in_pixel_rgb,
  output logic                         out_valid,
  output logic [rgbhsv_pkg::HUE_W-1:0] out_hue,
  output logic [rgbhsv_pkg::SAT_W-1:0] out_saturation,
  output logic [rgbhsv_pkg::CH_W-1:0]  out_brightness
);
  import rgbhsv_pkg::*;

  logic             in_xfer;
  logic             dvd_valid;
  side_t            dvd_side;
  logic [REM_W-1:0] hue_dvd, sat_dvd;
  logic [CH_W-1:0]  hue_dvs;
  logic             q_valid;
  side_t            q_side;
  logic [Q_W-1:0]   hue_q, sat_q;
  logic             hue_rem_nz;

  // Only reset blocks a transfer
  assign busy    = ~rst_n;
  assign in_xfer = start & ~busy;

  rgbhsv_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_xfer),
    .pixel_rgb (in_pixel_rgb),
    .dvd_valid (dvd_valid),
    .dvd_side  (dvd_side),
    .hue_dvd   (hue_dvd),
    .hue_dvs   (hue_dvs),
    .sat_dvd   (sat_dvd)
  );

  rgbhsv_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .dvd_valid  (dvd_valid),
    .dvd_side   (dvd_side),
    .hue_dvd    (hue_dvd),
    .hue_dvs    (hue_dvs),
    .sat_dvd    (sat_dvd),
    .q_valid    (q_valid),
    .q_side     (q_side),
    .hue_q      (hue_q),
    .hue_rem_nz (hue_rem_nz),
    .sat_q      (sat_q)
  );

  rgbhsv_post u_post (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_side         (q_side),
    .hue_q          (hue_q),
    .hue_rem_nz     (hue_rem_nz),
    .sat_q          (sat_q),
    .out_valid      (out_valid),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness)
  );

endmodule

>>> sv/rgbhsv_checker.sv
// Port-level checks for the RGB to HSV converter, bound to the top level.
// Depends on rgbhsv_pkg and rgb_to_hsv_converter_top.
`timescale 1ns / 1ps

module rgbhsv_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic [rgbhsv_pkg::HUE_W-1:0] out_hue,
  input logic [rgbhsv_pkg::SAT_W-1:0] out_saturation,
  input logic [rgbhsv_pkg::CH_W-1:0]  out_brightness
);
  import rgbhsv_pkg::*;

  localparam int unsigned CNT_W = $clog2(PIPE_LATENCY + 1);

  logic [CNT_W-1:0] warm_cnt_r;
  logic             warm;
  logic             in_xfer;

  // Pipeline is fully refilled once the warm-up counter reaches PIPE_LATENCY after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_cnt_r <= '0;
    end else if (!warm) begin
      warm_cnt_r <= warm_cnt_r + 1'b1;
    end
  end

  assign warm    = (warm_cnt_r == CNT_W'(PIPE_LATENCY));
  assign in_xfer = start & ~busy;

  // Every transfer yields exactly one result once the pipeline is warm
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    warm |-> (out_valid == $past(in_xfer, PIPE_LATENCY)))
    else $error("result strobe does not match transfer latency");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hue < HUE_W'(FULL_TURN)))
    else $error("hue out of range");

  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_saturation <= SAT_W'(256)))
    else $error("saturation out of range");

  // Black pixel carries no hue and no saturation
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_brightness == '0)) |-> ((out_hue == '0) && (out_saturation == '0)))
    else $error("black pixel with nonzero hue or saturation");

endmodule

bind rgb_to_hsv_converter_top rgbhsv_checker u_rgbhsv_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_hue        (out_hue),
  .out_saturation (out_saturation),
  .out_brightness (out_brightness)
);
